// File: design/qlvu_pkg.sv
// Shared types and constants of the Q-learning value update unit.
// No dependencies; imported by q_learning_value_update_unit.
`default_nettype none

package qlvu_pkg;

    // Field widths of the stream items
    localparam int STATE_W     = 10;
    localparam int ACTION_W    = 3;
    localparam int Q_W         = 24;
    localparam int RATE_W      = 16;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    // Configuration register map
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_LEARNING_RATE   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_DISCOUNT_FACTOR = 1'b1;
    localparam logic [RATE_W-1:0] LR_RESET    = 16'd6554;
    localparam logic [RATE_W-1:0] GAMMA_RESET = 16'd58982;

    // Datapath widths of the update arithmetic
    localparam int RC_W       = Q_W + 1;            // reward - Q
    localparam int FRAC_SHIFT = 16;                 // Q12.12 -> scale 2^-28
    localparam int GB_W       = Q_W + RATE_W;       // gamma * best
    localparam int MCAND_W    = 42;                 // difference term
    localparam int MPLR_W     = RATE_W + 3;         // lr * 4 or lr * 5
    localparam int PROD_W     = MCAND_W + MPLR_W;   // scale 2^-46
    localparam int RND_W      = PROD_W + 1;
    localparam int RND_SHIFT  = 34;
    localparam int DELTA_W    = RND_W - RND_SHIFT;
    localparam int SUM_W      = DELTA_W + 1;
    localparam logic [RND_W-1:0] ROUND_BIAS = 62'd1 << (RND_SHIFT - 1);
    localparam logic [Q_W-1:0]   Q_MAX_VAL  = 24'h7F_FFFF;
    localparam logic [Q_W-1:0]   Q_MIN_VAL  = 24'h80_0000;

    // Sequencer states, one-hot
    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_CUR   = 10'b00_0000_0010,
        S_SCAN  = 10'b00_0000_0100,
        S_LOAD  = 10'b00_0000_1000,
        S_MUL1  = 10'b00_0001_0000,
        S_DIFF  = 10'b00_0010_0000,
        S_MUL2  = 10'b00_0100_0000,
        S_ROUND = 10'b00_1000_0000,
        S_SUM   = 10'b01_0000_0000,
        S_OUT   = 10'b10_0000_0000
    } t_seq_state;

endpackage

`default_nettype wire

// File: design/q_learning_value_update_unit.sv
// Top level of the Q-learning value update unit: Q table, max scan and serial update datapath.
// Depends on qlvu_pkg.
`default_nettype none

// Keeps a table of STATE_COUNT*ACTION_COUNT signed Q12.12 values with a valid flag per
// entry and, for each input transfer, applies Q += lr*p*(r + gamma*max - Q) to entry
// (state, action), p being 1.25 for a negative reward, saturating to 24 bits. One result
// transfer (new Q, max of the next state) follows each input transfer. After reset the
// table is swept clear, one entry per cycle, and no input is accepted during the sweep.
// Each item then runs from accept to the next possible accept through one table read per
// cycle over the next state's entries and two 19-step bit-serial shift-add multiplies
// (gamma*max, then difference*lr*p) through one shared adder. The output register lets
// the next item start while a result waits.
module q_learning_value_update_unit #(
    parameter int STATE_COUNT  = 1024,
    parameter int ACTION_COUNT = 8
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // Input stream; tdata from bit 0: state_index[9:0], action_taken[2:0],
    // reward_value[23:0], next_state_index[9:0], one zero pad bit
    input  wire                                  i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  wire  [qlvu_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    // Result stream; tdata from bit 0: new_q_value[23:0], best_next_q[23:0]
    output logic                                 o_m_axis_tvalid,
    input  wire                                  i_m_axis_tready,
    output logic [qlvu_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    // Configuration write channel
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [qlvu_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  wire  [qlvu_pkg::RATE_W-1:0]          i_cfg_data
);
    import qlvu_pkg::*;

    localparam int DEPTH  = STATE_COUNT * ACTION_COUNT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(ACTION_COUNT + 1);
    localparam int STEP_W = $clog2(MPLR_W);

    // Input field unpacking
    logic [STATE_W-1:0]  in_state;
    logic [ACTION_W-1:0] in_action;
    logic [Q_W-1:0]      in_reward;
    logic [STATE_W-1:0]  in_next;
    logic                in_st_ok;
    logic                in_act_ok;
    logic                in_nxt_ok;
    logic                accept;

    assign in_state  = i_s_axis_tdata[STATE_W-1:0];
    assign in_action = i_s_axis_tdata[STATE_W +: ACTION_W];
    assign in_reward = i_s_axis_tdata[STATE_W+ACTION_W +: Q_W];
    assign in_next   = i_s_axis_tdata[STATE_W+ACTION_W+Q_W +: STATE_W];
    assign in_st_ok  = 32'(in_state) < STATE_COUNT;
    assign in_act_ok = 32'(in_action) < ACTION_COUNT;
    assign in_nxt_ok = 32'(in_next) < STATE_COUNT;

    // Control registers
    t_seq_state          r_state, n_state;
    logic                r_clr_busy;
    logic [ADDR_W-1:0]   r_clr_addr;
    logic [CNT_W-1:0]    r_cnt;
    logic [STEP_W-1:0]   r_step;
    logic                r_out_valid;
    logic [RATE_W-1:0]   r_lr;
    logic [RATE_W-1:0]   r_gamma;

    // Item payload registers
    logic [ADDR_W-1:0]   r_cur_idx;
    logic [ADDR_W-1:0]   r_nxt_base;
    logic [ACTION_W-1:0] r_act;
    logic [Q_W-1:0]      r_reward;
    logic                r_same;
    logic                r_nxt_ok;
    logic [Q_W-1:0]      r_cur;
    logic [Q_W-1:0]      r_best;
    logic                r_found;
    logic [RC_W-1:0]     r_rc;
    logic [MCAND_W-1:0]  r_mcand;
    logic [MCAND_W-1:0]  r_acc;
    logic [MPLR_W-1:0]   r_low;
    logic [DELTA_W-1:0]  r_delta;
    logic [Q_W-1:0]      r_nq;
    logic [OUT_TDATA_W-1:0] r_out_data;

    // Table: valid flag in the top bit over the Q value
    logic [Q_W:0]        r_table [DEPTH];
    logic [Q_W:0]        r_rd_data;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [Q_W:0]        mem_wdata;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_raddr;

    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE) && !r_clr_busy;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_cfg_ready     = 1'b1;

    // Scan: entry of the previous count arrives in r_rd_data
    logic [CNT_W-1:0]    k_prev;
    logic                ent_valid;
    logic [Q_W-1:0]      ent_val;
    logic                take_max;
    logic                scan_last;

    assign k_prev    = CNT_W'(r_cnt - 1'b1);
    assign scan_last = 32'(r_cnt) == ACTION_COUNT;

    always_comb begin
        ent_valid = r_rd_data[Q_W];
        ent_val   = r_rd_data[Q_W-1:0];
        // the current entry counts as valid with its pre-update value
        if (r_same && (32'(k_prev) == 32'(r_act))) begin
            ent_valid = 1'b1;
            ent_val   = r_cur;
        end
        take_max = r_nxt_ok && (r_cnt != '0) && ent_valid &&
                   (!r_found || ($signed(ent_val) > $signed(r_best)));
    end

    // Shared shift-add step: one multiplier bit per cycle, LSB first
    logic [MCAND_W:0]    mul_sum;
    logic                mul_last;

    assign mul_sum  = {r_acc[MCAND_W-1], r_acc} +
                      (r_low[0] ? {r_mcand[MCAND_W-1], r_mcand} : '0);
    assign mul_last = 32'(r_step) == (MPLR_W - 1);

    // Difference term and rate multiplier
    logic [PROD_W-1:0]   prod;
    logic [GB_W-1:0]     gb;
    logic [MCAND_W-1:0]  diff;
    logic [MPLR_W-1:0]   rate_mul;
    logic [RND_W-1:0]    rnd;
    logic [SUM_W-1:0]    nq_full;
    logic [Q_W-1:0]      nq_sat;

    assign prod = {r_acc, r_low};
    assign gb   = prod[GB_W-1:0];
    assign diff = {{(MCAND_W-RC_W-FRAC_SHIFT){r_rc[RC_W-1]}}, r_rc, {FRAC_SHIFT{1'b0}}} +
                  {{(MCAND_W-GB_W){gb[GB_W-1]}}, gb};
    assign rate_mul = {1'b0, r_lr, 2'b00} +
                      (r_reward[Q_W-1] ? {3'b000, r_lr} : '0);
    assign rnd = {prod[PROD_W-1], prod} + ROUND_BIAS;
    assign nq_full = {{(SUM_W-Q_W){r_cur[Q_W-1]}}, r_cur} + {r_delta[DELTA_W-1], r_delta};

    // Saturate to the Q12.12 range
    always_comb begin
        if ((nq_full[SUM_W-1:Q_W-1] == '0) || (nq_full[SUM_W-1:Q_W-1] == '1)) begin
            nq_sat = nq_full[Q_W-1:0];
        end else if (nq_full[SUM_W-1]) begin
            nq_sat = Q_MIN_VAL;
        end else begin
            nq_sat = Q_MAX_VAL;
        end
    end

    // Table port control
    always_comb begin
        mem_we    = r_clr_busy || (r_state == S_SUM);
        mem_waddr = r_clr_busy ? r_clr_addr : r_cur_idx;
        mem_wdata = r_clr_busy ? '0 : {1'b1, nq_sat};
        mem_re    = 1'b0;
        mem_raddr = r_cur_idx;
        if (r_state == S_CUR) begin
            mem_re = 1'b1;
        end else if ((r_state == S_SCAN) && r_nxt_ok && (32'(r_cnt) < ACTION_COUNT)) begin
            mem_re    = 1'b1;
            mem_raddr = r_nxt_base + ADDR_W'(r_cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_table[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_table[mem_raddr];
        end
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (in_st_ok && in_act_ok) ? S_CUR : S_OUT;
                end
            end
            S_CUR:   n_state = S_SCAN;
            S_SCAN:  if (scan_last) n_state = S_LOAD;
            S_LOAD:  n_state = S_MUL1;
            S_MUL1:  if (mul_last) n_state = S_DIFF;
            S_DIFF:  n_state = S_MUL2;
            S_MUL2:  if (mul_last) n_state = S_ROUND;
            S_ROUND: n_state = S_SUM;
            S_SUM:   n_state = S_OUT;
            S_OUT:   if (!r_out_valid || i_m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control state, clearing sweep and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_cnt       <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_lr        <= LR_RESET;
            r_gamma     <= GAMMA_RESET;
        end else begin
            r_state <= n_state;

            // sweep the table clear after reset
            if (r_clr_busy) begin
                r_clr_addr <= ADDR_W'(r_clr_addr + 1'b1);
                if (32'(r_clr_addr) == DEPTH - 1) begin
                    r_clr_busy <= 1'b0;
                end
            end

            // scan and multiply step counters
            if (accept) begin
                r_cnt <= '0;
            end else if (r_state == S_SCAN) begin
                r_cnt <= CNT_W'(r_cnt + 1'b1);
            end
            if ((r_state == S_LOAD) || (r_state == S_DIFF)) begin
                r_step <= '0;
            end else if ((r_state == S_MUL1) || (r_state == S_MUL2)) begin
                r_step <= STEP_W'(r_step + 1'b1);
            end

            // output register: drop on transfer, load from the last state
            if ((r_state == S_OUT) && (!r_out_valid || i_m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_LEARNING_RATE:   r_lr    <= i_cfg_data;
                    REG_DISCOUNT_FACTOR: r_gamma <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Item datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_act      <= in_action;
                    r_reward   <= in_reward;
                    r_cur_idx  <= ADDR_W'(32'(in_state) * ACTION_COUNT + 32'(in_action));
                    r_nxt_base <= ADDR_W'(32'(in_next) * ACTION_COUNT);
                    r_same     <= in_state == in_next;
                    r_nxt_ok   <= in_nxt_ok;
                    r_best     <= '0;
                    r_found    <= 1'b0;
                    r_nq       <= '0;
                end
            end
            S_SCAN: begin
                // first scan cycle sees the current entry, invalid reads as zero
                if (r_cnt == '0) begin
                    r_cur <= r_rd_data[Q_W] ? r_rd_data[Q_W-1:0] : '0;
                end
                if (take_max) begin
                    r_best  <= ent_val;
                    r_found <= 1'b1;
                end
            end
            S_LOAD: begin
                r_rc    <= {r_reward[Q_W-1], r_reward} - {r_cur[Q_W-1], r_cur};
                r_mcand <= {{(MCAND_W-Q_W){r_best[Q_W-1]}}, r_best};
                r_acc   <= '0;
                r_low   <= MPLR_W'(r_gamma);
            end
            S_MUL1, S_MUL2: begin
                r_acc <= mul_sum[MCAND_W:1];
                r_low <= {mul_sum[0], r_low[MPLR_W-1:1]};
            end
            S_DIFF: begin
                r_mcand <= diff;
                r_acc   <= '0;
                r_low   <= rate_mul;
            end
            S_ROUND: begin
                r_delta <= rnd[RND_W-1:RND_SHIFT];
            end
            S_SUM: begin
                r_nq <= nq_sat;
            end
            S_OUT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    r_out_data <= {r_best, r_nq};
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_accept_starts_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("accepted item did not leave idle");

    a_result_from_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("result loaded outside the output state");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (32'(r_cnt) <= ACTION_COUNT))
        else $error("scan count past action count");

    a_mul_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_MUL1) || (r_state == S_MUL2)) |-> (32'(r_step) < MPLR_W))
        else $error("multiply step past multiplier width");

    a_idle_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> ((r_state == S_IDLE) && !mem_re))
        else $error("item in flight during table clear");
`endif

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench of the Q-learning value update unit.
// Drives stream items and register writes, predicts every result transfer and compares.
// Depends on qlvu_pkg and q_learning_value_update_unit.
`default_nettype none

module tb_top;
    import qlvu_pkg::*;

    localparam int N_STATES    = 1024;
    localparam int N_ACTIONS   = 8;
    localparam int TABLE_SIZE  = N_STATES * N_ACTIONS;
    localparam int SETTLE_CYC  = 64;
    localparam int PHASE_ITEMS = 150;

    typedef struct packed {
        logic [STATE_W-1:0]  state;
        logic [ACTION_W-1:0] action;
        logic [Q_W-1:0]      reward;
        logic [STATE_W-1:0]  next_state;
    } t_update_req;

    typedef struct packed {
        logic [Q_W-1:0] new_q;
        logic [Q_W-1:0] best_q;
    } t_update_rsp;

    // Clock, reset and DUT-facing signals
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   in_vld = 1'b0;
    logic [IN_TDATA_W-1:0]  in_data = '0;
    logic                   out_rdy = 1'b0;
    logic                   cfg_vld = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_idx = '0;
    logic [RATE_W-1:0]      cfg_wdata = '0;
    wire                    o_s_axis_tready;
    wire                    o_m_axis_tvalid;
    wire [OUT_TDATA_W-1:0]  o_m_axis_tdata;
    wire                    o_cfg_ready;

    // Shadow copy of the Q table and registers
    logic [Q_W-1:0]    q_table [TABLE_SIZE];
    bit                q_known [TABLE_SIZE];
    logic [RATE_W-1:0] lr_reg = LR_RESET;
    logic [RATE_W-1:0] gamma_reg = GAMMA_RESET;

    t_update_req stim_q [$];
    t_update_rsp pending_results [$];
    int          sender_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          fail_count = 0;
    bit          keep_item;
    t_update_rsp exp_rsp;

    always #5 i_clk = ~i_clk;

    q_learning_value_update_unit #(
        .STATE_COUNT  (N_STATES),
        .ACTION_COUNT (N_ACTIONS)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (in_vld),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (in_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (out_rdy),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (cfg_vld),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_idx),
        .i_cfg_data      (cfg_wdata)
    );

    // Apply one update to the shadow table and return the expected result
    function automatic t_update_rsp update_q_entry(input t_update_req req);
        int          idx;
        longint      cur, best, rw, cand, diff, prod, delta, nq;
        bit          found;
        t_update_rsp rsp;
        best  = 0;
        found = 1'b0;
        rsp   = '0;
        if (int'(req.state) >= N_STATES || int'(req.action) >= N_ACTIONS) begin
            return rsp;
        end
        idx = int'(req.state) * N_ACTIONS + int'(req.action);
        // First touch writes zero, so the entry is valid before the scan
        if (!q_known[idx]) begin
            q_known[idx] = 1'b1;
            q_table[idx] = '0;
        end
        cur = longint'($signed(q_table[idx]));
        // Max over the valid entries of the next state, zero if none
        if (int'(req.next_state) < N_STATES) begin
            for (int k = 0; k < N_ACTIONS; k++) begin
                if (q_known[int'(req.next_state) * N_ACTIONS + k]) begin
                    cand = longint'($signed(q_table[int'(req.next_state) * N_ACTIONS + k]));
                    if (!found || cand > best) begin
                        best  = cand;
                        found = 1'b1;
                    end
                end
            end
        end
        rw    = longint'($signed(req.reward));
        diff  = rw * 65536 + longint'(gamma_reg) * best - cur * 65536;
        prod  = diff * longint'(lr_reg) * ((rw < 0) ? 5 : 4);
        delta = (prod + (longint'(1) << 33)) >>> 34;
        nq    = cur + delta;
        if (nq > 8388607) nq = 8388607;
        if (nq < -8388608) nq = -8388608;
        q_table[idx] = Q_W'(nq);
        rsp.new_q  = Q_W'(nq);
        rsp.best_q = Q_W'(best);
        return rsp;
    endfunction

    function automatic logic [IN_TDATA_W-1:0] pack_request(input t_update_req req);
        return {1'b0, req.next_state, req.reward, req.action, req.state};
    endfunction

    task automatic queue_update(input int st, input int act, input int rw, input int nxt);
        t_update_req req;
        req.state      = STATE_W'(st);
        req.action     = ACTION_W'(act);
        req.reward     = Q_W'(rw);
        req.next_state = STATE_W'(nxt);
        stim_q.push_back(req);
    endtask

    // Mostly a small pool of hot states so that values build up
    function automatic int pick_state();
        if ($urandom_range(0, 99) < 80) return $urandom_range(0, 15);
        return $urandom_range(0, N_STATES - 1);
    endfunction

    function automatic int pick_reward();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40) return $urandom_range(0, 32768) - 16384;
        if (sel < 80) return int'($signed(Q_W'($urandom)));
        case (sel % 4)
            0: return 8388607;
            1: return -8388608;
            2: return 0;
            default: return -1;
        endcase
    endfunction

    task automatic queue_random_updates(input int count);
        int st, nsel, nxt;
        for (int i = 0; i < count; i++) begin
            st   = pick_state();
            nsel = $urandom_range(0, 99);
            if (nsel < 70) nxt = $urandom_range(0, 15);
            else if (nsel < 85) nxt = st;
            else nxt = $urandom_range(0, N_STATES - 1);
            queue_update(st, $urandom_range(0, N_ACTIONS - 1), pick_reward(), nxt);
        end
    endtask

    // Write one register through the configuration channel
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [RATE_W-1:0] val);
        @(posedge i_clk);
        cfg_vld   <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_vld <= 1'b0;
        case (idx)
            REG_LEARNING_RATE:   lr_reg = val;
            REG_DISCOUNT_FACTOR: gamma_reg = val;
            default: ;
        endcase
    endtask

    task automatic set_rates(input logic [RATE_W-1:0] lr, input logic [RATE_W-1:0] gamma);
        write_reg(REG_LEARNING_RATE, lr);
        write_reg(REG_DISCOUNT_FACTOR, gamma);
    endtask

    // Hold the sender until every expected result has come back
    task automatic drain();
        while (stim_q.size() != 0 || in_vld || pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        drain();
    endtask

    // Driver: present the oldest pending item, hold it until the transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_vld <= 1'b0;
        end else begin
            keep_item = in_vld && !o_s_axis_tready;
            if (in_vld && o_s_axis_tready) begin
                pending_results.push_back(update_q_entry(stim_q.pop_front()));
            end
            if (!keep_item) begin
                if (stim_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                    in_vld  <= 1'b1;
                    in_data <= pack_request(stim_q[0]);
                end else begin
                    in_vld <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_rdy <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && out_rdy) begin
                if (pending_results.size() == 0) begin
                    $error("result transfer with no update pending: %h", o_m_axis_tdata);
                    fail_count++;
                end else begin
                    exp_rsp = pending_results.pop_front();
                    if (o_m_axis_tdata[Q_W-1:0] !== exp_rsp.new_q) begin
                        $error("new_q_value: expected %0d, actual %0d",
                               $signed(exp_rsp.new_q), $signed(o_m_axis_tdata[Q_W-1:0]));
                        fail_count++;
                    end
                    if (o_m_axis_tdata[2*Q_W-1:Q_W] !== exp_rsp.best_q) begin
                        $error("best_next_q: expected %0d, actual %0d",
                               $signed(exp_rsp.best_q), $signed(o_m_axis_tdata[2*Q_W-1:Q_W]));
                        fail_count++;
                    end
                end
            end
            out_rdy <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Stimulus sequence
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Default rates: first touch, self loop, empty next state, bit patterns
        set_rates(LR_RESET, GAMMA_RESET);
        queue_update(0, 0, 0, 0);
        queue_update(1023, 7, 8388607, 1023);
        queue_update(1023, 7, -8388608, 1023);
        queue_update(5, 3, -1, 6);
        queue_update(6, 0, 4096, 5);
        queue_update(5, 3, 1, 5);
        queue_update(10'h2AA, 5, 24'h555555, 10'h155);
        queue_update(10'h155, 2, int'($signed(24'hAAAAAA)), 10'h2AA);
        run_phase(0, 0);

        // Full rates: drive an entry into both saturation limits
        set_rates(16'hFFFF, 16'hFFFF);
        repeat (4) queue_update(9, 1, 8388607, 9);
        repeat (4) queue_update(9, 1, -8388608, 9);
        queue_update(10, 0, -8388608, 11);
        run_phase(0, 0);

        // Zero rates leave values unchanged
        set_rates(16'h0000, 16'h0000);
        queue_update(9, 1, 8388607, 9);
        queue_update(5, 3, -8388608, 6);
        queue_update(6, 0, 12345, 5);
        run_phase(0, 0);

        // Random phases with different rates and idling patterns
        set_rates(16'($urandom), 16'($urandom));
        queue_random_updates(PHASE_ITEMS);
        run_phase(0, 0);

        set_rates(16'hFFFF, 16'h0000);
        queue_random_updates(PHASE_ITEMS);
        run_phase(69, 0);

        set_rates(16'h0001, 16'hFFFF);
        queue_random_updates(PHASE_ITEMS);
        run_phase(0, 69);

        set_rates(16'($urandom), 16'($urandom));
        queue_random_updates(PHASE_ITEMS);
        run_phase(10, 10);

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
